FILE: sv/hhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_pkg
// Shared types and constants for the heartbeat hang watchdog.
// ----------------------------------------------------------------------------
package hhw_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int REQ_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;
  // 4095 s * 1000 fits in 22 bits
  localparam int MS_W          = 22;

  localparam logic [MS_W-1:0] MS_PER_SEC = MS_W'(1000);

  typedef enum logic [REQ_W-1:0] {
    REQ_PULSE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_GRACE = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_KILL      = 2'd1,
    CFG_WIN_WATCH = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    SRC_HEARTBEAT = 1'b0,
    SRC_WINDOW    = 1'b1
  } hang_src_t;

  typedef struct packed {
    logic            timeout_off;
    logic [MS_W-1:0] timeout_ms;
    logic            kill_en;
    logic [MS_W-1:0] kill_ms;
    logic            win_en;
  } cfg_t;

endpackage

FILE: sv/hhw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_req_if
// Request channel: pulse, tick or grace request with valid/ready.
// ----------------------------------------------------------------------------
interface hhw_req_if #(
  parameter int TIME_BITS = hhw_pkg::TIME_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [hhw_pkg::REQ_W-1:0]  req_type;
  logic [TIME_BITS-1:0]       now_ms;
  logic [TIME_BITS-1:0]       grace_until_ms;
  logic                       window_found;
  logic                       window_hung;

  modport source (
    output valid, req_type, now_ms, grace_until_ms, window_found, window_hung,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, grace_until_ms, window_found, window_hung,
    output ready
  );
endinterface

FILE: sv/hhw_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_res_if
// Result channel: one watchdog result per request, valid/ready.
// ----------------------------------------------------------------------------
interface hhw_res_if #(
  parameter int TIME_BITS = hhw_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 tick_skipped;
  logic                 hang_fired;
  logic                 hang_source;
  logic                 recovered;
  logic [TIME_BITS-1:0] recovery_ms;
  logic                 kill_request;

  modport source (
    output valid, tick_skipped, hang_fired, hang_source, recovered, recovery_ms,
           kill_request,
    input  ready
  );
  modport sink (
    input  valid, tick_skipped, hang_fired, hang_source, recovered, recovery_ms,
           kill_request,
    output ready
  );
endinterface

FILE: sv/hhw_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ----------------------------------------------------------------------------
interface hhw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hhw_pkg::CFG_IDX_W-1:0]  index;
  logic [hhw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hhw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_cfg
// Configuration registers; timeouts are kept pre-scaled to milliseconds.
// ----------------------------------------------------------------------------
module hhw_cfg (
  input  logic          clk,
  input  logic          rst_n,
  hhw_cfg_if.sink       cfg_ch,
  output hhw_pkg::cfg_t cfg
);

  logic [hhw_pkg::MS_W-1:0] timeout_ms_r, timeout_ms_nxt;
  logic [hhw_pkg::MS_W-1:0] kill_ms_r, kill_ms_nxt;
  logic                     win_en_r, win_en_nxt;
  logic [hhw_pkg::MS_W-1:0] data_ms;

  assign cfg_ch.ready = 1'b1;
  assign data_ms = hhw_pkg::MS_W'(cfg_ch.data) * hhw_pkg::MS_PER_SEC;

  always_comb begin
    timeout_ms_nxt = timeout_ms_r;
    kill_ms_nxt    = kill_ms_r;
    win_en_nxt     = win_en_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        hhw_pkg::CFG_TIMEOUT:   timeout_ms_nxt = data_ms;
        hhw_pkg::CFG_KILL:      kill_ms_nxt    = data_ms;
        hhw_pkg::CFG_WIN_WATCH: win_en_nxt     = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms_r <= '0;
      kill_ms_r    <= '0;
      win_en_r     <= 1'b0;
    end else begin
      timeout_ms_r <= timeout_ms_nxt;
      kill_ms_r    <= kill_ms_nxt;
      win_en_r     <= win_en_nxt;
    end
  end

  assign cfg.timeout_off = (timeout_ms_r == '0);
  assign cfg.timeout_ms  = timeout_ms_r;
  assign cfg.kill_en     = (kill_ms_r != '0);
  assign cfg.kill_ms     = kill_ms_r;
  assign cfg.win_en      = win_en_r;

endmodule

FILE: sv/hhw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_core
// Watchdog state and per-request decision logic, one request per step.
// ----------------------------------------------------------------------------
module hhw_core #(
  parameter int TIME_BITS = hhw_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hhw_pkg::cfg_t             cfg,
  input  logic                      step,
  input  logic [hhw_pkg::REQ_W-1:0] req_type,
  input  logic [TIME_BITS-1:0]      now_ms,
  input  logic [TIME_BITS-1:0]      grace_until_ms,
  input  logic                      window_found,
  input  logic                      window_hung,
  output logic                      tick_skipped,
  output logic                      hang_fired,
  output logic                      hang_source,
  output logic                      recovered,
  output logic [TIME_BITS-1:0]      recovery_ms,
  output logic                      kill_request
);

  logic [TIME_BITS-1:0] last_pulse_r, last_pulse_nxt;
  logic [TIME_BITS-1:0] fired_pulse_r, fired_pulse_nxt;
  logic [TIME_BITS-1:0] hang_start_r, hang_start_nxt;
  logic                 hang_pending_r, hang_pending_nxt;
  logic [TIME_BITS-1:0] grace_end_r, grace_end_nxt;
  logic                 win_flag_r, win_flag_nxt;
  logic                 win_alive_r, win_alive_nxt;
  logic [TIME_BITS-1:0] win_since_r, win_since_nxt;

  logic [TIME_BITS-1:0] timeout_ms;
  logic [TIME_BITS-1:0] kill_ms;
  logic [TIME_BITS-1:0] d_pulse;
  logic [TIME_BITS-1:0] d_start;
  logic [TIME_BITS-1:0] since_eff;
  logic [TIME_BITS-1:0] d_since;
  logic                 kill_hit;

  assign timeout_ms = TIME_BITS'(cfg.timeout_ms);
  assign kill_ms    = TIME_BITS'(cfg.kill_ms);
  assign d_pulse    = now_ms - last_pulse_r;
  assign d_start    = now_ms - hang_start_r;
  assign since_eff  = (win_since_r == '0) ? now_ms : win_since_r;
  assign d_since    = now_ms - since_eff;
  assign kill_hit   = cfg.kill_en && (d_start > kill_ms);

  always_comb begin
    last_pulse_nxt   = last_pulse_r;
    fired_pulse_nxt  = fired_pulse_r;
    hang_start_nxt   = hang_start_r;
    hang_pending_nxt = hang_pending_r;
    grace_end_nxt    = grace_end_r;
    win_flag_nxt     = win_flag_r;
    win_alive_nxt    = win_alive_r;
    win_since_nxt    = win_since_r;
    tick_skipped     = 1'b0;
    hang_fired       = 1'b0;
    hang_source      = hhw_pkg::SRC_HEARTBEAT;
    recovered        = 1'b0;
    recovery_ms      = '0;
    kill_request     = 1'b0;

    unique case (req_type)
      hhw_pkg::REQ_PULSE: last_pulse_nxt = now_ms;
      hhw_pkg::REQ_GRACE: grace_end_nxt  = grace_until_ms;
      hhw_pkg::REQ_TICK: begin
        priority if (cfg.timeout_off || (now_ms < grace_end_r)) begin
          tick_skipped = 1'b1;
        end else if (last_pulse_r != '0) begin
          // heartbeat detector
          if (last_pulse_r != fired_pulse_r) begin
            if (hang_pending_r) begin
              recovered        = 1'b1;
              recovery_ms      = d_start;
              hang_pending_nxt = 1'b0;
            end
            if (d_pulse > timeout_ms) begin
              fired_pulse_nxt  = last_pulse_r;
              hang_start_nxt   = now_ms;
              hang_pending_nxt = 1'b1;
              hang_fired       = 1'b1;
              hang_source      = hhw_pkg::SRC_HEARTBEAT;
            end
          end else begin
            kill_request = kill_hit;
          end
        end else if (cfg.win_en && window_found) begin
          // window detector
          if (!window_hung) begin
            win_alive_nxt = 1'b1;
            if (win_flag_r && hang_pending_r) begin
              recovered        = 1'b1;
              recovery_ms      = d_start;
              hang_pending_nxt = 1'b0;
            end
            win_flag_nxt  = 1'b0;
            win_since_nxt = '0;
          end else if (win_alive_r) begin
            win_since_nxt = since_eff;
            if (d_since >= timeout_ms) begin
              if (!win_flag_r) begin
                win_flag_nxt     = 1'b1;
                hang_start_nxt   = now_ms;
                hang_pending_nxt = 1'b1;
                hang_fired       = 1'b1;
                hang_source      = hhw_pkg::SRC_WINDOW;
              end else begin
                kill_request = kill_hit;
              end
            end
          end
        end else begin
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pulse_r   <= '0;
      fired_pulse_r  <= '1;
      hang_start_r   <= '0;
      hang_pending_r <= 1'b0;
      grace_end_r    <= '0;
      win_flag_r     <= 1'b0;
      win_alive_r    <= 1'b0;
      win_since_r    <= '0;
    end else if (step) begin
      last_pulse_r   <= last_pulse_nxt;
      fired_pulse_r  <= fired_pulse_nxt;
      hang_start_r   <= hang_start_nxt;
      hang_pending_r <= hang_pending_nxt;
      grace_end_r    <= grace_end_nxt;
      win_flag_r     <= win_flag_nxt;
      win_alive_r    <= win_alive_nxt;
      win_since_r    <= win_since_nxt;
    end
  end

endmodule

FILE: sv/heartbeat_hang_watchdog_top.sv
`timescale 1ns / 1ps
// a request goes to the input register, then its result to the result register
// throughput: one request per cycle when unstalled (single decision stage in hhw_core)
// a result held at the output lets one more request into the input register, then stalls
// reset (rst_n low, synchronous): pipeline emptied, configuration cleared,
// watchdog state back to no pulse seen and no hang pending
// ----------------------------------------------------------------------------
// heartbeat_hang_watchdog_top
// Heartbeat and window-probe hang watchdog with kill request generation.
// ----------------------------------------------------------------------------
module heartbeat_hang_watchdog_top #(
  parameter int TIME_BITS = hhw_pkg::TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hhw_req_if.sink   in_ch,
  hhw_res_if.source out_ch,
  hhw_cfg_if.sink   cfg_ch
);

  hhw_pkg::cfg_t cfg;

  logic                      stg_valid_r, stg_valid_nxt;
  logic [hhw_pkg::REQ_W-1:0] stg_req_r;
  logic [TIME_BITS-1:0]      stg_now_r;
  logic [TIME_BITS-1:0]      stg_grace_r;
  logic                      stg_found_r;
  logic                      stg_hung_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_skip_r;
  logic                      out_fired_r;
  logic                      out_src_r;
  logic                      out_rec_r;
  logic [TIME_BITS-1:0]      out_rec_ms_r;
  logic                      out_kill_r;

  logic                      adv;
  logic                      in_acc;
  logic                      step;
  logic                      c_skip, c_fired, c_src, c_rec, c_kill;
  logic [TIME_BITS-1:0]      c_rec_ms;

  hhw_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !stg_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign step         = stg_valid_r && adv;

  hhw_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step           (step),
    .req_type       (stg_req_r),
    .now_ms         (stg_now_r),
    .grace_until_ms (stg_grace_r),
    .window_found   (stg_found_r),
    .window_hung    (stg_hung_r),
    .tick_skipped   (c_skip),
    .hang_fired     (c_fired),
    .hang_source    (c_src),
    .recovered      (c_rec),
    .recovery_ms    (c_rec_ms),
    .kill_request   (c_kill)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_acc) begin
      stg_valid_nxt = 1'b1;
    end else if (adv) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? stg_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_req_r   <= in_ch.req_type;
      stg_now_r   <= in_ch.now_ms;
      stg_grace_r <= in_ch.grace_until_ms;
      stg_found_r <= in_ch.window_found;
      stg_hung_r  <= in_ch.window_hung;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_skip_r   <= c_skip;
      out_fired_r  <= c_fired;
      out_src_r    <= c_src;
      out_rec_r    <= c_rec;
      out_rec_ms_r <= c_rec_ms;
      out_kill_r   <= c_kill;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tick_skipped = out_skip_r;
  assign out_ch.hang_fired   = out_fired_r;
  assign out_ch.hang_source  = out_src_r;
  assign out_ch.recovered    = out_rec_r;
  assign out_ch.recovery_ms  = out_rec_ms_r;
  assign out_ch.kill_request = out_kill_r;

endmodule

FILE: sim/hhw_verdict_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhw_verdict_check
// Watches the request, result and configuration channels of the hang
// watchdog, keeps its own copy of the watchdog state, predicts the result of
// every accepted request and compares each accepted result field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hhw_verdict_check (
  input  logic clk,
  input  logic rst_n,
  hhw_req_if   req,
  hhw_res_if   res,
  hhw_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  import hhw_pkg::*;

  localparam int TW = TIME_BITS_DEF;

  typedef struct packed {
    logic          skipped;
    logic          fired;
    logic          source;
    logic          recovered;
    logic [TW-1:0] recovery_ms;
    logic          kill;
  } verdict_t;

  logic [CFG_DATA_W-1:0] tmo_sec;
  logic [CFG_DATA_W-1:0] kill_sec;
  logic                  win_watch;

  logic [TW-1:0] beat_at;
  logic [TW-1:0] fired_beat;
  logic [TW-1:0] hang_at;
  logic          hang_open;
  logic [TW-1:0] grace_to;
  logic          win_flagged;
  logic          win_alive;
  logic [TW-1:0] win_since;

  verdict_t verdict;
  verdict_t due_q[$];

  function automatic logic [TW-1:0] elapsed(input logic [TW-1:0] later,
                                            input logic [TW-1:0] earlier);
    return later - earlier;
  endfunction

  function automatic logic [63:0] to_ms(input logic [CFG_DATA_W-1:0] sec);
    return 64'(sec) * 64'(MS_PER_SEC);
  endfunction

  function automatic void close_hang(input logic [TW-1:0] now);
    if (hang_open) begin
      hang_open           = 1'b0;
      verdict.recovered   = 1'b1;
      verdict.recovery_ms = elapsed(now, hang_at);
    end
  endfunction

  function automatic void open_hang(input logic [TW-1:0] now, input hang_src_t src);
    hang_at        = now;
    hang_open      = 1'b1;
    verdict.fired  = 1'b1;
    verdict.source = src;
  endfunction

  function automatic void check_kill(input logic [TW-1:0] now);
    if (kill_sec != '0 && 64'(elapsed(now, hang_at)) > to_ms(kill_sec))
      verdict.kill = 1'b1;
  endfunction

  function automatic verdict_t judge(input logic [REQ_W-1:0] kind,
                                     input logic [TW-1:0] now,
                                     input logic [TW-1:0] grace,
                                     input logic found,
                                     input logic hung);
    verdict = '0;
    case (kind)
      REQ_PULSE: beat_at = now;
      REQ_GRACE: grace_to = grace;
      REQ_TICK: begin
        if (tmo_sec == '0 || now < grace_to) begin
          verdict.skipped = 1'b1;
        end else if (beat_at != '0) begin
          if (beat_at != fired_beat) begin
            close_hang(now);
            if (64'(elapsed(now, beat_at)) > to_ms(tmo_sec)) begin
              fired_beat = beat_at;
              open_hang(now, SRC_HEARTBEAT);
            end
          end else begin
            check_kill(now);
          end
        end else if (win_watch && found) begin
          if (!hung) begin
            win_alive = 1'b1;
            if (win_flagged)
              close_hang(now);
            win_flagged = 1'b0;
            win_since   = '0;
          end else if (win_alive) begin
            // a hung window at time zero keeps reseeding the timer
            if (win_since == '0)
              win_since = now;
            if (64'(elapsed(now, win_since)) >= to_ms(tmo_sec)) begin
              if (!win_flagged) begin
                win_flagged = 1'b1;
                open_hang(now, SRC_WINDOW);
              end else begin
                check_kill(now);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return verdict;
  endfunction

  function automatic void cmp(input string tag, input logic [TW-1:0] want,
                              input logic [TW-1:0] got);
    if (got !== want) begin
      $display("%0t ns mismatch %s: expected %0h actual %0h", $time, tag, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      tmo_sec     = '0;
      kill_sec    = '0;
      win_watch   = 1'b0;
      beat_at     = '0;
      fired_beat  = '1;
      hang_at     = '0;
      hang_open   = 1'b0;
      grace_to    = '0;
      win_flagged = 1'b0;
      win_alive   = 1'b0;
      win_since   = '0;
      due_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TIMEOUT:   tmo_sec = cfg.data;
          CFG_KILL:      kill_sec = cfg.data;
          CFG_WIN_WATCH: win_watch = cfg.data[0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        due_q.push_back(judge(req.req_type, req.now_ms, req.grace_until_ms,
                              req.window_found, req.window_hung));
      if (res.valid && res.ready) begin
        if (due_q.size() == 0) begin
          $display("%0t ns unexpected result: expected none actual skip=%0b fire=%0b",
                   $time, res.tick_skipped, res.hang_fired);
          errors++;
        end else begin
          want = due_q.pop_front();
          cmp("tick_skipped", TW'(want.skipped), TW'(res.tick_skipped));
          cmp("hang_fired", TW'(want.fired), TW'(res.hang_fired));
          cmp("hang_source", TW'(want.source), TW'(res.hang_source));
          cmp("recovered", TW'(want.recovered), TW'(res.recovered));
          cmp("recovery_ms", want.recovery_ms, res.recovery_ms);
          cmp("kill_request", TW'(want.kill), TW'(res.kill_request));
        end
      end
    end
    pending <= due_q.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the hang watchdog with a directed opening (reset values, grace
// window, window detector, heartbeat hang, kill and recovery, odd request
// codes) and then phases of random pulse, tick and grace traffic under
// several register settings and idle patterns. Results are checked by
// hhw_verdict_check running beside the block.
// ----------------------------------------------------------------------------
module tb;
  import hhw_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam logic [REQ_W-1:0]     REQ_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   DRAIN_CYCLES = 6;

  logic          clk;
  logic          rst_n;
  int            in_idle_pct  = 33;
  int            out_idle_pct = 82;
  int            hold_ask     = 0;
  int            fault_cnt;
  int            in_flight;
  logic [TW-1:0] wall;
  logic          win_hung_now;
  int            quiet_left;
  int unsigned   tmo_span;

  hhw_req_if req_ch ();
  hhw_res_if res_ch ();
  hhw_cfg_if cfg_ch ();

  heartbeat_hang_watchdog_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  hhw_verdict_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (fault_cnt),
    .pending (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != seen) begin
        seen      = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic logic [TW-1:0] rand48();
    return TW'({$urandom, $urandom});
  endfunction

  function automatic logic [TW-1:0] next_step();
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return '0;
    else if (r < 55)
      return TW'($urandom_range(tmo_span / 8));
    else if (r < 90)
      return TW'($urandom_range(tmo_span * 3 / 2, tmo_span / 4));
    else
      return TW'($urandom_range(tmo_span * 3, tmo_span));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [TW-1:0] now,
                              input logic [TW-1:0] grace, input logic found,
                              input logic hung);
    while ($urandom_range(99) < in_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.now_ms         <= now;
    req_ch.grace_until_ms <= grace;
    req_ch.window_found   <= found;
    req_ch.window_hung    <= hung;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // wait until every predicted result has come back, then a further drain wait
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] tmo,
                           input logic [CFG_DATA_W-1:0] kill, input logic win);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_KILL, kill);
    write_reg(CFG_WIN_WATCH, CFG_DATA_W'(win));
    cfg_ch.valid <= 1'b0;
    tmo_span = (tmo == '0) ? 5000 : int'(tmo) * 1000;
  endtask

  task automatic run_random(input int count, input bit press);
    int r;
    for (int i = 0; i < count; i++) begin
      if (press && i == count / 3)
        hold_ask <= hold_ask + 1;
      if (press && i == 2 * count / 3)
        settle();
      r = $urandom_range(99);
      if (r < 6) begin
        send_request(REQ_W'($urandom_range(3)), rand48(), rand48(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        wall = wall + next_step();
        if (r < 9 && quiet_left == 0) begin
          // back to no pulse seen, then keep pulses away for a while
          send_request(REQ_PULSE, '0, rand48(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          quiet_left = $urandom_range(40, 10);
        end else if (r < 14) begin
          send_request(REQ_GRACE, rand48(), wall + TW'($urandom_range(tmo_span * 2)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end else if (r < 40 && quiet_left == 0) begin
          send_request(REQ_PULSE, wall, rand48(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end else begin
          if (quiet_left > 0)
            quiet_left--;
          if ($urandom_range(99) < 15)
            win_hung_now = !win_hung_now;
          send_request(REQ_TICK, wall, rand48(), ($urandom_range(19) != 0), win_hung_now);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] tmo,
                           input logic [CFG_DATA_W-1:0] kill, input logic win,
                           input int in_pct, input int out_pct, input int count,
                           input bit press);
    settle();
    configure(tmo, kill, win);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    run_random(count, press);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_PULSE;
    req_ch.now_ms         <= '0;
    req_ch.grace_until_ms <= '0;
    req_ch.window_found   <= 1'b0;
    req_ch.window_hung    <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_TIMEOUT;
    cfg_ch.data           <= '0;
    wall         = '0;
    win_hung_now = 1'b0;
    quiet_left   = 0;
    tmo_span     = 5000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // timeout still zero after reset
    send_request(REQ_TICK, TW'(5), '0, 1'b1, 1'b0);
    settle();
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(2));
    write_reg(CFG_KILL, CFG_DATA_W'(1));
    write_reg(CFG_WIN_WATCH, CFG_DATA_W'(1));
    write_reg(CFG_SPARE, '1);
    cfg_ch.valid <= 1'b0;

    send_request(REQ_SPARE, '1, '1, 1'b1, 1'b1);
    // pulse at all ones equals the reset fired value: kill path, no hang
    send_request(REQ_PULSE, '1, '0, 1'b0, 1'b0);
    send_request(REQ_TICK, '1, rand48(), 1'b1, 1'b1);
    send_request(REQ_PULSE, '0, rand48(), 1'b0, 1'b0);
    // window detector
    send_request(REQ_TICK, TW'(100), rand48(), 1'b0, 1'b1);
    send_request(REQ_TICK, TW'(200), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(300), rand48(), 1'b1, 1'b0);
    send_request(REQ_TICK, TW'(400), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(2400), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(3500), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(3600), rand48(), 1'b1, 1'b0);
    // grace window
    send_request(REQ_GRACE, rand48(), TW'(10000), 1'b0, 1'b0);
    send_request(REQ_TICK, TW'(9999), rand48(), 1'b1, 1'b0);
    send_request(REQ_TICK, TW'(10000), rand48(), 1'b1, 1'b0);
    // heartbeat hang, kill and recovery
    send_request(REQ_PULSE, TW'(10500), rand48(), 1'b0, 1'b0);
    send_request(REQ_TICK, TW'(12500), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(12501), rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, TW'(13502), rand48(), 1'b1, 1'b1);
    send_request(REQ_PULSE, TW'(14000), rand48(), 1'b0, 1'b0);
    send_request(REQ_TICK, TW'(14001), rand48(), 1'b1, 1'b0);
    // hung window at time zero
    send_request(REQ_GRACE, rand48(), '0, 1'b0, 1'b0);
    send_request(REQ_PULSE, '0, rand48(), 1'b0, 1'b0);
    send_request(REQ_TICK, '0, rand48(), 1'b1, 1'b1);
    send_request(REQ_TICK, '0, rand48(), 1'b1, 1'b1);
    wall = TW'(14001);

    run_phase(2, 3, 1'b1, 33, 82, 350, 1'b0);
    run_phase(4095, 4095, 1'b1, 33, 82, 300, 1'b0);
    run_phase(1, 0, 1'b0, 82, 33, 300, 1'b0);
    run_phase(0, 1, 1'b1, 82, 33, 120, 1'b0);
    run_phase(3600, 3600, 1'b1, 0, 0, 300, 1'b1);
    run_phase(CFG_DATA_W'($urandom_range(6, 1)), CFG_DATA_W'($urandom_range(6)),
              1'($urandom_range(1)), 0, 0, 350, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(6, 1)), CFG_DATA_W'($urandom_range(6)),
              1'b1, 0, 0, 300, 1'b0);

    settle();
    if (fault_cnt == 0 && in_flight == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
